// ----- rtl/core/sdra_pkg.sv -----
// ----------------------------------------------------------------------------
// sdra_pkg: shared types, constants and fp32 arithmetic
// Binary32 multiply and add with round-to-nearest-even, subnormal support
// and a canonical quiet NaN on every NaN result.
// ----------------------------------------------------------------------------
`default_nettype none

package sdra_pkg;

  localparam int LANES    = 4;
  localparam int IO_LANES = 4;
  localparam int GROUPS   = 64;
  localparam int GRP_W    = 6;
  localparam int ADDR_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int FP_W     = 32;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] ALPHA_RST = 32'h3F80_0000;
  localparam logic [31:0] BETA_RST  = 32'h0000_0000;

  localparam logic KIND_TERM    = 1'b0;
  localparam logic KIND_ROW_END = 1'b1;

  // Register select is the word bit of the byte address.
  localparam logic REG_ALPHA = 1'b0;
  localparam logic REG_BETA  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_PROD,
    S_SUM,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              rd_en;
    logic              prod_en;
    logic              sum_en;
    logic              wr_en;
    logic              row_end;
    logic              skip;
    logic [ADDR_W-1:0] addr;
  } lane_ctl_t;

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic               s;
    logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, found;
    logic [7:0]         ea, eb;
    logic [23:0]        ma, mb, m;
    logic [47:0]        p, pn;
    logic [5:0]         lz;
    logic signed [10:0] e;
    logic [6:0]         sh;
    logic [95:0]        t;
    logic               g, st;
    logic [30:0]        mag;
    logic [31:0]        r;
    s      = a[31] ^ b[31];
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma     = {a[30:23] != 8'd0, a[22:0]};
    mb     = {b[30:23] != 8'd0, b[22:0]};
    p      = ma * mb;
    lz     = 6'd0;
    found  = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && p[i]) begin
        lz    = 6'(47 - i);
        found = 1'b1;
      end
    end
    pn = p << lz;
    e  = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd126 - $signed({5'b0, lz});
    sh = 7'd0;
    if (e < 11'sd1) begin
      sh = ((11'sd1 - e) > 11'sd50) ? 7'd50 : 7'(11'sd1 - e);
      e  = 11'sd1;
    end
    t   = {pn, 48'd0} >> sh;
    m   = t[95:72];
    g   = t[71];
    st  = |t[70:0];
    mag = {8'(e - 11'sd1), 23'd0} + 31'(m) + 31'(g & (st | m[0]));
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      r = CANON_NAN;
    end else if (a_inf || b_inf) begin
      r = {s, 8'hFF, 23'd0};
    end else if (a_zero || b_zero) begin
      r = {s, 31'd0};
    end else if (e >= 11'sd255) begin
      r = {s, 8'hFF, 23'd0};
    end else begin
      r = {s, mag};
    end
    return r;
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]        x, y, r;
    logic               a_nan, b_nan, a_inf, b_inf, found;
    logic [7:0]         ex, ey, d;
    logic [4:0]         dc;
    logic [23:0]        mx, my, m;
    logic [50:0]        w;
    logic [26:0]        ya;
    logic [27:0]        sum;
    logic [4:0]         lz;
    logic signed [9:0]  e;
    logic               g, st;
    logic [30:0]        mag;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    if (a[30:0] < b[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    ex  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey  = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx  = {x[30:23] != 8'd0, x[22:0]};
    my  = {y[30:23] != 8'd0, y[22:0]};
    d   = ex - ey;
    dc  = (d > 8'd31) ? 5'd31 : d[4:0];
    w   = {my, 27'd0} >> dc;
    ya  = {w[50:25], w[24] | (|w[23:0])};
    if (x[31] ^ y[31]) begin
      sum = {1'b0, mx, 3'd0} - {1'b0, ya};
    end else begin
      sum = {1'b0, mx, 3'd0} + {1'b0, ya};
    end
    e = $signed({2'b0, ex});
    if (sum[27]) begin
      sum = {1'b0, sum[27:2], sum[1] | sum[0]};
      e   = e + 10'sd1;
    end else begin
      lz    = 5'd0;
      found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
        if (!found && sum[i]) begin
          lz    = 5'(26 - i);
          found = 1'b1;
        end
      end
      if ($signed({5'b0, lz}) > (e - 10'sd1)) begin
        lz = 5'(e - 10'sd1);
      end
      sum = sum << lz;
      e   = e - $signed({5'b0, lz});
    end
    m   = sum[26:3];
    g   = sum[2];
    st  = |sum[1:0];
    mag = {8'(e - 10'sd1), 23'd0} + 31'(m) + 31'(g & (st | m[0]));
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
      r = CANON_NAN;
    end else if (a_inf) begin
      r = a;
    end else if (b_inf) begin
      r = b;
    end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      r = {a[31] & b[31], 31'd0};
    end else if (sum == 28'd0) begin
      r = 32'd0;
    end else if (e >= 10'sd255) begin
      r = {x[31], 8'hFF, 23'd0};
    end else begin
      r = {x[31], mag};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sparse_dense_row_accumulate_core.sv -----
// ----------------------------------------------------------------------------
// sparse_dense_row_accumulate_core: fp32 sparse row times dense accumulate
// Accumulates alpha*a*B terms per group of output columns and emits
// y = acc + beta*c_old at row end.
// ----------------------------------------------------------------------------
// Usage: the input stream carries one item per transfer. tuser selects a
// term item (accumulate a_value*alpha*b into the group's four lanes) or a
// row-end item (emit the group's results and clear it). A row-end item gives
// one output item with the group number and four fp32 results; a term item
// gives none. alpha and beta sit on the APB port at byte addresses 0 and 4
// and must be written only while the block is idle; the block itself does not enforce this.
// Each in-range item passes through acceptance, the alpha multiply, the lane
// multiply, the lane add and the write-back, set by the single sequencer
// stepping each item through the shared lane datapath one stage at a time.
// A row-end result is loaded into the output register in the write-back step.
// The output register holds a result while the receiver stalls; a further
// row-end item then waits in its last step until the register frees up.
// Reset sets alpha to 1.0, beta to +0.0 and all accumulators to +0.0 at once.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_dense_row_accumulate_core
  import sdra_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // group_index[5:0], a_value[37:6], b_lane0..3[165:38], c_lane0..3[293:166]
  input  wire logic [295:0] s_axis_tdata_i,
  // kind[0]
  input  wire logic [0:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // out_group[5:0], y_lane0..3[133:6]
  output logic [135:0]      m_axis_tdata_o,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  state_e state_q, state_d;
  logic [31:0] alpha_q, beta_q;
  logic        kind_q;
  logic [GRP_W-1:0] grp_q;
  logic [FP_W-1:0]  a_q;
  logic [IO_LANES*FP_W-1:0] b_q, c_q;
  logic [FP_W-1:0]  v_q;
  logic [LANES*FP_W-1:0] y_lanes;
  lane_ctl_t ctl;
  logic accept, in_range, out_free, out_load;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BETA) ? beta_q : alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RST;
      beta_q  <= BETA_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_BETA) begin
        beta_q <= pwdata;
      end else begin
        alpha_q <= pwdata;
      end
    end
  end

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_range = {1'b0, s_axis_tdata_i[GRP_W-1:0]} < (GRP_W+1)'(GROUPS);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= s_axis_tuser_i[0];
      grp_q  <= s_axis_tdata_i[5:0];
      a_q    <= s_axis_tdata_i[37:6];
      b_q    <= s_axis_tdata_i[165:38];
      c_q    <= s_axis_tdata_i[293:166];
    end
    if (state_q == S_SCALE) begin
      v_q <= fp_mul(a_q, alpha_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    out_load        = 1'b0;
    ctl             = '0;
    ctl.addr        = grp_q[ADDR_W-1:0];
    ctl.row_end     = (kind_q == KIND_ROW_END);
    ctl.skip        = (beta_q[30:0] == 31'd0);
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        // Items for groups beyond the chunk are dropped without effect.
        if (s_axis_tvalid_i && in_range) begin
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        ctl.rd_en = 1'b1;
        state_d   = S_PROD;
      end
      S_PROD: begin
        ctl.prod_en = 1'b1;
        state_d     = S_SUM;
      end
      S_SUM: begin
        ctl.sum_en = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (kind_q == KIND_TERM) begin
          ctl.wr_en = 1'b1;
          state_d   = S_IDLE;
        end else if (out_free) begin
          ctl.wr_en = 1'b1;
          out_load  = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    logic [FP_W-1:0] b_lane, c_lane;
    assign b_lane = (j < IO_LANES) ? b_q[(j%IO_LANES)*FP_W +: FP_W] : '0;
    assign c_lane = (j < IO_LANES) ? c_q[(j%IO_LANES)*FP_W +: FP_W] : '0;
    sdra_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .b_i    (b_lane),
      .c_i    (c_lane),
      .v_i    (v_q),
      .beta_i (beta_q),
      .y_o    (y_lanes[j*FP_W +: FP_W])
    );
  end

  sdra_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (out_load),
    .grp_i    (grp_q),
    .y_i      (y_lanes),
    .free_o   (out_free),
    .tvalid_o (m_axis_tvalid_o),
    .tready_i (m_axis_tready_i),
    .tdata_o  (m_axis_tdata_o)
  );

  a_row_end_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && kind_q == KIND_ROW_END && !out_free) |=> state_q == S_DONE)
    else $error("row-end item left its last step without a free output register");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q) == S_DONE && $past(kind_q) == KIND_ROW_END)
    else $error("output item appeared without a finished row");

  a_scale_to_prod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCALE |=> state_q == S_PROD)
    else $error("sequencer skipped the lane multiply step");

endmodule

`default_nettype wire

// ----- rtl/core/sdra_lane.sv -----
// ----------------------------------------------------------------------------
// sdra_lane: one accumulator lane
// Holds the lane's accumulator memory, forms the lane product and the
// rounded sum, and writes back or clears the addressed group.
// ----------------------------------------------------------------------------
`default_nettype none

module sdra_lane
  import sdra_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire lane_ctl_t       ctl_i,
  input  wire logic [FP_W-1:0] b_i,
  input  wire logic [FP_W-1:0] c_i,
  input  wire logic [FP_W-1:0] v_i,
  input  wire logic [FP_W-1:0] beta_i,
  output logic      [FP_W-1:0] y_o
);

  logic [FP_W-1:0] mem_q [GROUPS];
  logic [GROUPS-1:0] valid_q;
  logic [FP_W-1:0] rdata_q;
  logic            rvld_q;
  logic [FP_W-1:0] prod_q;
  logic [FP_W-1:0] sum_q;
  logic [FP_W-1:0] acc;

  // Entries never written since reset or since their row ended read as +0.
  assign acc = rvld_q ? rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[ctl_i.addr];
    end
    if (ctl_i.wr_en && !ctl_i.row_end) begin
      mem_q[ctl_i.addr] <= sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (ctl_i.rd_en) begin
        rvld_q <= valid_q[ctl_i.addr];
      end
      if (ctl_i.wr_en) begin
        valid_q[ctl_i.addr] <= !ctl_i.row_end;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.prod_en) begin
      prod_q <= ctl_i.row_end ? fp_mul(beta_i, c_i) : fp_mul(b_i, v_i);
    end
    if (ctl_i.sum_en) begin
      sum_q <= (ctl_i.row_end && ctl_i.skip) ? acc : fp_add(acc, prod_q);
    end
  end

  assign y_o = sum_q;

endmodule

`default_nettype wire

// ----- rtl/core/sdra_merge.sv -----
// ----------------------------------------------------------------------------
// sdra_merge: result merge and output register
// Gathers the lane results of a finished row into one output item and
// holds it until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sdra_merge
  import sdra_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    load_i,
  input  wire logic [GRP_W-1:0]        grp_i,
  input  wire logic [LANES*FP_W-1:0]   y_i,
  output logic                         free_o,
  output logic                         tvalid_o,
  input  wire logic                    tready_i,
  output logic [135:0]                 tdata_o
);

  logic                       valid_q;
  logic [GRP_W-1:0]           grp_q;
  logic [IO_LANES*FP_W-1:0]   y_q;
  logic [IO_LANES*FP_W-1:0]   y_io;

  always_comb begin
    y_io = '0;
    for (int j = 0; j < IO_LANES; j++) begin
      if (j < LANES) begin
        y_io[j*FP_W +: FP_W] = y_i[j*FP_W +: FP_W];
      end
    end
  end

  assign free_o = !valid_q || tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_i;
      y_q   <= y_io;
    end
  end

  assign tvalid_o = valid_q;
  assign tdata_o  = {2'b00, y_q, grp_q};

endmodule

`default_nettype wire
